FILE: design/vector_field_trilinear_sampler_macros.svh
// Assertion helpers for the trilinear sampler checker.
`ifndef VECTOR_FIELD_TRILINEAR_SAMPLER_MACROS_SVH
`define VECTOR_FIELD_TRILINEAR_SAMPLER_MACROS_SVH

// Same-cycle implication.
`define VFTS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define VFTS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/vfts_pkg.sv
package vfts_pkg;

  localparam int unsigned STORE_AW    = 12;
  localparam int unsigned STORE_DEPTH = 4096;
  localparam int unsigned FIELD_W     = 24;
  localparam int unsigned CELL_W      = 8;
  localparam int unsigned FRAC_W      = 17;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam logic [FRAC_W-1:0] ONE_Q16 = 17'h10000;

  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_X    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_Y    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_Z    = 3'd5;

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  typedef logic signed [FIELD_W-1:0] field_t;

  // one node word as stored: {z, y, x}
  typedef struct packed {
    field_t fz;
    field_t fy;
    field_t fx;
  } node_t;

endpackage

FILE: design/vector_field_trilinear_sampler.sv
// Trilinear sampler over a 3-D grid of three-component vectors.
// Input channel (in_valid_i / in_stall_o): op selects a node write (node_index,
// node_field_*) or a sample at pos_* (signed Q16.16). A beat is taken when
// valid is high and stall is low; one beat can be taken every cycle.
// Output channel (out_valid_o / out_stall_i): one sample_* beat per sample
// beat, in order; writes give no output beat.
// Config port (cfg_valid_i / cfg_ready_o): ready is always high; write the
// origin and inverse spacing registers only while the pipeline is empty.
// Throughput: one item per cycle while the output is not stalled, set by the
// nine-stage pipeline whose eight corner reads come from four copies of the
// node store, two read ports each.
// A write lands in the store when it reaches stage 5, so any sample behind
// it sees the new node.
// Reset clears the registers (origin 0, inverse spacing 1.0) and all valid
// bits; the node store holds nothing defined until nodes are written.
// While the output beat is stalled, the whole pipeline holds and in_stall_o
// is raised; nothing is dropped or repeated.
module vector_field_trilinear_sampler
  import vfts_pkg::*;
#(
  parameter int unsigned GRID_NX = 16,
  parameter int unsigned GRID_NY = 16,
  parameter int unsigned GRID_NZ = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 op_i,
  input  logic [11:0]          node_index_i,
  input  logic signed [23:0]   node_field_x_i,
  input  logic signed [23:0]   node_field_y_i,
  input  logic signed [23:0]   node_field_z_i,
  input  logic signed [31:0]   pos_x_i,
  input  logic signed [31:0]   pos_y_i,
  input  logic signed [31:0]   pos_z_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic signed [23:0]   sample_x_o,
  output logic signed [23:0]   sample_y_o,
  output logic signed [23:0]   sample_z_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]          cfg_data_i
);

  localparam int unsigned NAX [3] = '{GRID_NX, GRID_NY, GRID_NZ};
  localparam int unsigned PLANE   = GRID_NX * GRID_NY;

  logic en;
  logic out_valid_q;

  // configuration
  logic signed [31:0] org_q [3];
  logic [31:0]        inv_q [3];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < 3; a++) begin
        org_q[a] <= '0;
        inv_q[a] <= 32'h0001_0000;
      end
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_ORIGIN_X: org_q[0] <= cfg_data_i;
        CFG_ORIGIN_Y: org_q[1] <= cfg_data_i;
        CFG_ORIGIN_Z: org_q[2] <= cfg_data_i;
        CFG_INV_X:    inv_q[0] <= cfg_data_i;
        CFG_INV_Y:    inv_q[1] <= cfg_data_i;
        CFG_INV_Z:    inv_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // whole pipeline moves together; it holds only while the result is stalled
  assign en         = !(out_valid_q && out_stall_i);
  assign in_stall_o = !en;

  logic [8:1] v_q;
  logic [5:1] op_q;
  logic [STORE_AW-1:0] widx_q [5:1];
  node_t               wdat_q [5:1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q[1] <= in_valid_i;
      for (int s = 2; s <= 5; s++) v_q[s] <= v_q[s-1];
      // only samples go past the store
      v_q[6] <= v_q[5] && (op_q[5] == OP_SAMPLE);
      v_q[7] <= v_q[6];
      v_q[8] <= v_q[7];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      op_q[1]   <= op_i;
      widx_q[1] <= node_index_i;
      wdat_q[1] <= '{fz: node_field_z_i, fy: node_field_y_i, fx: node_field_x_i};
      for (int s = 2; s <= 5; s++) begin
        op_q[s]   <= op_q[s-1];
        widx_q[s] <= widx_q[s-1];
        wdat_q[s] <= wdat_q[s-1];
      end
    end
  end

  // stage 1: offset from origin, as sign and magnitude
  logic signed [31:0] pos [3];
  assign pos[0] = pos_x_i;
  assign pos[1] = pos_y_i;
  assign pos[2] = pos_z_i;

  logic        neg1_d [3], neg1_q [3];
  logic [32:0] mag1_d [3], mag1_q [3];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      logic signed [32:0] d;
      d = 33'(pos[a]) - 33'(org_q[a]);
      neg1_d[a] = d[32];
      mag1_d[a] = d[32] ? (33'd0 - 33'(d)) : 33'(d);
    end
  end

  // stage 2: magnitude times inverse spacing, as two partial products
  logic        neg2_q [3];
  logic [47:0] pplo2_q [3];
  logic [48:0] pphi2_q [3];

  // stage 3: grid coordinate in Q.16
  logic signed [50:0] g3_d [3], g3_q [3];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      logic [64:0] p;
      logic [48:0] gm;
      p  = (65'(pphi2_q[a]) << 16) + 65'(pplo2_q[a]);
      gm = neg2_q[a] ? 49'((p + 65'd65535) >> 16) : 49'(p >> 16);
      g3_d[a] = neg2_q[a] ? -$signed({2'b00, gm}) : $signed({2'b00, gm});
    end
  end

  // stage 4: clamped cell and fraction
  logic [CELL_W-1:0] c4_d [3], c4_q [3];
  logic [FRAC_W-1:0] t4_d [3], t4_q [3];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      if (g3_q[a][50]) begin
        c4_d[a] = '0;
        t4_d[a] = '0;
      end else if (g3_q[a][49:16] > 34'(NAX[a] - 2)) begin
        c4_d[a] = CELL_W'(NAX[a] - 2);
        t4_d[a] = ONE_Q16;
      end else begin
        c4_d[a] = g3_q[a][16 +: CELL_W];
        t4_d[a] = {1'b0, g3_q[a][15:0]};
      end
    end
  end

  // stage 5: corner addresses and first weight products
  logic [STORE_AW-1:0] addr5_d [8], addr5_q [8];
  logic [33:0]         axy5_d [4], axy5_q [4];
  logic [FRAC_W-1:0]   az5_q [2];

  always_comb begin
    logic [31:0] base;
    logic [FRAC_W-1:0] ax [2];
    logic [FRAC_W-1:0] ay [2];
    base = (32'(c4_q[2]) * 32'(GRID_NY) + 32'(c4_q[1])) * 32'(GRID_NX) + 32'(c4_q[0]);
    for (int b = 0; b < 8; b++) begin
      addr5_d[b] = STORE_AW'(base + 32'(b & 1) + 32'((b >> 1) & 1) * 32'(GRID_NX)
                             + 32'((b >> 2) & 1) * 32'(PLANE));
    end
    ax[0] = ONE_Q16 - t4_q[0];
    ax[1] = t4_q[0];
    ay[0] = ONE_Q16 - t4_q[1];
    ay[1] = t4_q[1];
    for (int j = 0; j < 4; j++) axy5_d[j] = 34'(ax[j & 1]) * 34'(ay[j >> 1]);
  end

  // node store: four identical copies, two reads each
  logic  wr_en;
  node_t rd6 [8];
  assign wr_en = en && v_q[5] && (op_q[5] == OP_WRITE);

  for (genvar k = 0; k < 4; k++) begin : g_copy
    node_t mem [STORE_DEPTH];
    node_t rd0_q, rd1_q;
    always_ff @(posedge clk_i) begin
      if (wr_en) mem[widx_q[5]] <= wdat_q[5];
      if (en) begin
        rd0_q <= mem[addr5_q[2*k]];
        rd1_q <= mem[addr5_q[2*k+1]];
      end
    end
    assign rd6[2*k]   = rd0_q;
    assign rd6[2*k+1] = rd1_q;
  end

  // stage 6: rounded Q1.16 weights
  logic [FRAC_W-1:0] w6_d [8], w6_q [8];

  always_comb begin
    for (int b = 0; b < 8; b++) begin
      logic [50:0] pr;
      pr = 51'(axy5_q[b & 3]) * 51'(az5_q[b >> 2]);
      w6_d[b] = FRAC_W'((pr + 51'h8000_0000) >> 32);
    end
  end

  // stage 7: weight times node value
  logic signed [41:0] pr7_d [8][3], pr7_q [8][3];

  always_comb begin
    for (int b = 0; b < 8; b++) begin
      logic signed [17:0] ws;
      ws = $signed({1'b0, w6_q[b]});
      pr7_d[b][0] = 42'(ws * rd6[b].fx);
      pr7_d[b][1] = 42'(ws * rd6[b].fy);
      pr7_d[b][2] = 42'(ws * rd6[b].fz);
    end
  end

  // stage 8: half sums
  logic signed [44:0] hs8_d [2][3], hs8_q [2][3];

  always_comb begin
    for (int h = 0; h < 2; h++) begin
      for (int c = 0; c < 3; c++) begin
        hs8_d[h][c] = 45'(pr7_q[4*h][c]) + 45'(pr7_q[4*h+1][c])
                    + 45'(pr7_q[4*h+2][c]) + 45'(pr7_q[4*h+3][c]);
      end
    end
  end

  // stage 9: final sum, round half up, saturate
  field_t res_d [3], res_q [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      logic signed [45:0] acc;
      logic signed [29:0] r;
      acc = 46'(hs8_q[0][c]) + 46'(hs8_q[1][c]) + 46'sd32768;
      r   = 30'(acc >>> 16);
      if (r > 30'sd8388607) begin
        res_d[c] = 24'sh7FFFFF;
      end else if (r < -30'sd8388608) begin
        res_d[c] = 24'sh800000;
      end else begin
        res_d[c] = r[23:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        neg1_q[a]  <= neg1_d[a];
        mag1_q[a]  <= mag1_d[a];
        neg2_q[a]  <= neg1_q[a];
        pplo2_q[a] <= 48'(mag1_q[a][15:0]) * 48'(inv_q[a]);
        pphi2_q[a] <= 49'(mag1_q[a][32:16]) * 49'(inv_q[a]);
        g3_q[a]    <= g3_d[a];
        c4_q[a]    <= c4_d[a];
        t4_q[a]    <= t4_d[a];
        res_q[a]   <= res_d[a];
      end
      for (int b = 0; b < 8; b++) begin
        addr5_q[b] <= addr5_d[b];
        w6_q[b]    <= w6_d[b];
        for (int c = 0; c < 3; c++) pr7_q[b][c] <= pr7_d[b][c];
      end
      for (int j = 0; j < 4; j++) axy5_q[j] <= axy5_d[j];
      az5_q[0] <= ONE_Q16 - t4_q[2];
      az5_q[1] <= t4_q[2];
      for (int h = 0; h < 2; h++) begin
        for (int c = 0; c < 3; c++) hs8_q[h][c] <= hs8_d[h][c];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= v_q[8];
    end
  end

  assign out_valid_o = out_valid_q;
  assign sample_x_o  = res_q[0];
  assign sample_y_o  = res_q[1];
  assign sample_z_o  = res_q[2];

endmodule

FILE: design/vfts_checker.sv
`include "vector_field_trilinear_sampler_macros.svh"

module vfts_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_stall_o,
  input logic out_valid_o,
  input logic out_stall_i,
  input logic cfg_valid_i,
  input logic cfg_ready_o
);

  `VFTS_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o, "output beat dropped")
  `VFTS_ASSERT_NOW(a_stall_back, out_valid_o && out_stall_i, in_stall_o, "input not held on stall")
  `VFTS_ASSERT_NOW(a_no_idle_stall, !out_valid_o, !in_stall_o, "input stalled with empty output")
  `VFTS_ASSERT_NOW(a_cfg_ready, cfg_valid_i, cfg_ready_o, "config write refused")

endmodule

bind vector_field_trilinear_sampler vfts_checker u_vfts_checker (.*);

FILE: bench/tb.sv
`timescale 1ns / 100ps

module tb;
  import vfts_pkg::*;

  localparam int NX = 16;
  localparam int NY = 16;
  localparam int NZ = 16;

  typedef struct {
    logic        op;
    logic [11:0] nidx;
    field_t      fx, fy, fz;
    logic signed [31:0] px, py, pz;
  } grid_beat_t;

  typedef struct {
    field_t sx, sy, sz;
  } vec_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic op_i = OP_WRITE;
  logic [11:0] node_index_i = '0;
  logic signed [23:0] node_field_x_i = '0, node_field_y_i = '0, node_field_z_i = '0;
  logic signed [31:0] pos_x_i = '0, pos_y_i = '0, pos_z_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b1;
  logic signed [23:0] sample_x_o, sample_y_o, sample_z_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = CFG_ORIGIN_X;
  logic [31:0] cfg_data_i = '0;

  vector_field_trilinear_sampler #(.GRID_NX(NX), .GRID_NY(NY), .GRID_NZ(NZ)) uut (.*);

  always #2 clk_i = ~clk_i;

  grid_beat_t pending_beats[$];
  vec_t       expected_samples[$];
  node_t      node_mirror[STORE_DEPTH];
  bit         node_loaded[STORE_DEPTH];
  logic [31:0] grid_cfg[6];
  int errors = 0;
  bit running = 0;

  // per axis: clamped cell and Q1.16 fraction
  function automatic void grid_axis(input logic signed [31:0] p, input logic signed [31:0] o,
                                    input logic [31:0] inv, input int n,
                                    output int ci, output longint tq);
    longint d, g, c;
    longint unsigned mag, prod;
    d = longint'(p) - longint'(o);
    mag = (d < 0) ? longint'(-d) : longint'(d);
    prod = mag * {32'd0, inv};
    g = (d >= 0) ? longint'(prod >> 16) : -longint'((prod + 64'd65535) >> 16);
    c = g >>> 16;
    if (c > n - 2) c = n - 2;
    if (c < 0) c = 0;
    tq = g - c * 65536;
    if (tq < 0) tq = 0;
    if (tq > 65536) tq = 65536;
    ci = int'(c);
  endfunction

  function automatic int corner_addr(int i, int j, int k);
    return (((k * NY) + j) * NX + i) & (STORE_DEPTH - 1);
  endfunction

  function automatic field_t round_sat(longint acc);
    longint r;
    r = (acc + 32768) >>> 16;
    if (r > 8388607) r = 8388607;
    if (r < -8388608) r = -8388608;
    return field_t'(r);
  endfunction

  function automatic vec_t interp_sample(grid_beat_t b);
    int cx, cy, cz, a;
    longint tx, ty, tz, w, ax[2], ay[2], az[2], accx, accy, accz;
    longint unsigned prod;
    vec_t v;
    grid_axis(b.px, grid_cfg[CFG_ORIGIN_X], grid_cfg[CFG_INV_X], NX, cx, tx);
    grid_axis(b.py, grid_cfg[CFG_ORIGIN_Y], grid_cfg[CFG_INV_Y], NY, cy, ty);
    grid_axis(b.pz, grid_cfg[CFG_ORIGIN_Z], grid_cfg[CFG_INV_Z], NZ, cz, tz);
    ax[0] = 65536 - tx; ax[1] = tx;
    ay[0] = 65536 - ty; ay[1] = ty;
    az[0] = 65536 - tz; az[1] = tz;
    accx = 0; accy = 0; accz = 0;
    for (int c = 0; c < 8; c++) begin
      prod = ax[c & 1] * ay[(c >> 1) & 1] * az[(c >> 2) & 1];
      w = longint'((prod + 64'h8000_0000) >> 32);
      a = corner_addr(cx + (c & 1), cy + ((c >> 1) & 1), cz + ((c >> 2) & 1));
      accx += w * longint'(node_mirror[a].fx);
      accy += w * longint'(node_mirror[a].fy);
      accz += w * longint'(node_mirror[a].fz);
    end
    v.sx = round_sat(accx);
    v.sy = round_sat(accy);
    v.sz = round_sat(accz);
    return v;
  endfunction

  function automatic grid_beat_t rand_beat();
    grid_beat_t b;
    b.op = OP_WRITE;
    b.nidx = 12'($urandom);
    b.fx = field_t'($urandom); b.fy = field_t'($urandom); b.fz = field_t'($urandom);
    b.px = $urandom; b.py = $urandom; b.pz = $urandom;
    return b;
  endfunction

  function automatic void queue_write(int a, bit full_scale, bit neg);
    grid_beat_t b;
    b = rand_beat();
    b.nidx = 12'(a);
    if (full_scale) begin
      b.fx = neg ? 24'sh800000 : 24'sh7fffff;
      b.fy = b.fx; b.fz = b.fx;
    end
    node_loaded[a] = 1;
    pending_beats.push_back(b);
  endfunction

  // any corner never loaded is written first, so no undefined node is read
  function automatic void queue_sample(logic signed [31:0] px, logic signed [31:0] py,
                                       logic signed [31:0] pz, bit full_scale);
    grid_beat_t b;
    int cx, cy, cz, a;
    longint t;
    grid_axis(px, grid_cfg[CFG_ORIGIN_X], grid_cfg[CFG_INV_X], NX, cx, t);
    grid_axis(py, grid_cfg[CFG_ORIGIN_Y], grid_cfg[CFG_INV_Y], NY, cy, t);
    grid_axis(pz, grid_cfg[CFG_ORIGIN_Z], grid_cfg[CFG_INV_Z], NZ, cz, t);
    for (int c = 0; c < 8; c++) begin
      a = corner_addr(cx + (c & 1), cy + ((c >> 1) & 1), cz + ((c >> 2) & 1));
      if (!node_loaded[a] || full_scale) queue_write(a, full_scale, $urandom_range(0, 1));
    end
    b = rand_beat();
    b.op = OP_SAMPLE;
    b.px = px; b.py = py; b.pz = pz;
    pending_beats.push_back(b);
  endfunction

  function automatic logic signed [31:0] rand_pos(logic signed [31:0] o);
    if ($urandom_range(0, 3) == 0) return $urandom;
    return o + $signed($urandom_range(0, 32'h0014_0000)) - 32'sh0002_0000;
  endfunction

  // input driver
  grid_beat_t cur_beat;
  int in_gap = 0;
  bit in_quiet = 0;
  always @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      if (cur_beat.op == OP_WRITE)
        node_mirror[cur_beat.nidx] = '{fz: cur_beat.fz, fy: cur_beat.fy, fx: cur_beat.fx};
      else
        expected_samples.push_back(interp_sample(cur_beat));
    end
    if (running && (!in_valid_i || !in_stall_o)) begin
      if (in_gap > 0) begin
        in_gap--;
        in_valid_i <= 1'b0;
      end else if (pending_beats.size() > 0) begin
        cur_beat = pending_beats.pop_front();
        op_i <= cur_beat.op;
        node_index_i <= cur_beat.nidx;
        node_field_x_i <= cur_beat.fx;
        node_field_y_i <= cur_beat.fy;
        node_field_z_i <= cur_beat.fz;
        pos_x_i <= cur_beat.px;
        pos_y_i <= cur_beat.py;
        pos_z_i <= cur_beat.pz;
        in_valid_i <= 1'b1;
        if ($urandom_range(0, 39) == 0) in_quiet = !in_quiet;
        in_gap = in_quiet ? 0 : $urandom_range(0, 9);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // output monitor
  int out_wait = 0;
  bit out_quiet = 0;
  vec_t want;
  always @(posedge clk_i) begin
    if (running) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_samples.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected sample beat %h %h %h",
                                     sample_x_o, sample_y_o, sample_z_o);
        end else begin
          want = expected_samples.pop_front();
          if (want.sx !== sample_x_o || want.sy !== sample_y_o || want.sz !== sample_z_o)
          begin
            errors++;
            if (errors <= 10)
              $display("sample mismatch: exp %h %h %h got %h %h %h",
                       want.sx, want.sy, want.sz, sample_x_o, sample_y_o, sample_z_o);
          end
        end
        if ($urandom_range(0, 39) == 0) out_quiet = !out_quiet;
        out_wait = out_quiet ? 0 : $urandom_range(0, 9);
      end
      if (out_wait > 0) begin
        out_wait--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx < 6) grid_cfg[idx] = data;
    cfg_valid_i <= 1'b0;
  endtask

  task automatic drain();
    while (pending_beats.size() > 0 || in_valid_i || expected_samples.size() > 0)
      @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  // count is in input beats, corner loads included
  task automatic random_phase(int count);
    while (pending_beats.size() < count) begin
      if ($urandom_range(0, 9) < 6)
        queue_sample(rand_pos(grid_cfg[CFG_ORIGIN_X]), rand_pos(grid_cfg[CFG_ORIGIN_Y]),
                     rand_pos(grid_cfg[CFG_ORIGIN_Z]), $urandom_range(0, 19) == 0);
      else
        queue_write($urandom_range(0, STORE_DEPTH - 1), 0, 0);
    end
    drain();
  endtask

  initial begin
    grid_cfg = '{0, 0, 0, 32'h10000, 32'h10000, 32'h10000};
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    running = 1;

    // directed: exact node, mid cell, far corner, clamping, extremes
    queue_write(0, 1, 0);
    queue_write(STORE_DEPTH - 1, 1, 1);
    queue_sample(32'sh0, 32'sh0, 32'sh0, 0);
    queue_sample(32'sh8000, 32'sh8000, 32'sh8000, 1);
    queue_sample(32'sh8000, 32'sh8000, 32'sh8000, 0);
    queue_sample(32'sh000F_0000, 32'sh000F_0000, 32'sh000F_0000, 0);
    queue_sample(-32'sh0005_0000, 32'sh0003_4000, 32'sh0020_0000, 0);
    queue_sample(32'sh7fff_ffff, 32'sh8000_0000, 32'sh0, 0);
    queue_sample(32'sh000E_ffff, 32'sh0000_0001, 32'sh000E_0000, 0);
    drain();

    // extreme registers plus indexes past the register list
    cfg_write(CFG_ORIGIN_X, 32'h8000_0000);
    cfg_write(CFG_ORIGIN_Y, 32'h7fff_ffff);
    cfg_write(CFG_ORIGIN_Z, 32'h0);
    cfg_write(CFG_INV_X, 32'h1);
    cfg_write(CFG_INV_Y, 32'hffff_ffff);
    cfg_write(CFG_INV_Z, 32'h8000);
    cfg_write(3'd6, $urandom);
    cfg_write(3'd7, $urandom);
    queue_sample(32'h8000_0000, 32'h7fff_ffff, 32'h0, 0);
    queue_sample(32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 0);
    random_phase(300);

    cfg_write(CFG_ORIGIN_X, $urandom_range(0, 32'h0004_0000) - 32'h0002_0000);
    cfg_write(CFG_ORIGIN_Y, $urandom_range(0, 32'h0004_0000) - 32'h0002_0000);
    cfg_write(CFG_ORIGIN_Z, $urandom_range(0, 32'h0004_0000) - 32'h0002_0000);
    cfg_write(CFG_INV_X, $urandom_range(32'h8000, 32'h40000));
    cfg_write(CFG_INV_Y, $urandom_range(32'h8000, 32'h40000));
    cfg_write(CFG_INV_Z, $urandom_range(32'h8000, 32'h40000));
    random_phase(350);

    for (int r = 0; r < 6; r++) cfg_write(r[CFG_IDX_W-1:0], $urandom_range(1, 32'hffff_ffff));
    random_phase(250);

    cfg_write(CFG_ORIGIN_X, 32'h0);
    cfg_write(CFG_ORIGIN_Y, 32'h0);
    cfg_write(CFG_ORIGIN_Z, 32'h0);
    cfg_write(CFG_INV_X, 32'h10000);
    cfg_write(CFG_INV_Y, 32'h10000);
    cfg_write(CFG_INV_Z, 32'h10000);
    random_phase(350);

    if (errors == 0 && expected_samples.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
